// ===== design/lfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_pkg: shared types and constants of the lowest free id allocator
// Holds the request and result word layouts, operation and status codes,
// and the small bit helpers used by the datapath.
// ----------------------------------------------------------------------------
package lfa_pkg;

  localparam int ID_W      = 12;
  localparam int MAX_ID_W  = 13;
  localparam int STATUS_W  = 2;
  localparam int INIT_BYTES = 32;
  localparam int BYTES_PER_WORD = 8;
  localparam int WORD_W    = 64;

  localparam logic [7:0] BYTE_FULL = 8'hFF;
  localparam logic [MAX_ID_W-1:0] MAX_ID_RESET = 13'd256;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd2;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] release_id;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]     given_id;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // Index of the lowest clear bit of a byte, 0 when the byte is full.
  function automatic logic [2:0] lowest_clear_bit(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  // Index of the first byte of a word that still has a clear bit.
  function automatic logic [2:0] first_open_byte(input logic [WORD_W-1:0] w);
    logic [2:0] r;
    r = 3'd0;
    for (int k = BYTES_PER_WORD - 1; k >= 0; k--) begin
      if (w[k*8 +: 8] != BYTE_FULL) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lfa_bitmap_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_bitmap_mem: id bitmap storage
// One write port, one read port with registered data. A per-word valid bit
// makes never-written words read as all free without a clearing pass.
// ----------------------------------------------------------------------------
module lfa_bitmap_mem #(
  parameter int NUM_WORDS = 64,
  parameter int WIDX_W    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        we,
  input  wire logic [WIDX_W-1:0]           waddr,
  input  wire logic [lfa_pkg::WORD_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [WIDX_W-1:0]           raddr,
  output logic      [lfa_pkg::WORD_W-1:0]  rdata
);

  logic [lfa_pkg::WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]       valid_r;
  logic [lfa_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/lfa_full_summary.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_full_summary: one full flag per bitmap word
// Tracks which words have every id taken and points at the first word
// that still has a free id.
// ----------------------------------------------------------------------------
module lfa_full_summary #(
  parameter int NUM_WORDS = 64,
  parameter int WIDX_W    = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              upd_en,
  input  wire logic [WIDX_W-1:0] upd_idx,
  input  wire logic              upd_full,
  output logic      [WIDX_W-1:0] first_idx,
  output logic                   any_open
);

  logic [NUM_WORDS-1:0] full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else if (upd_en) begin
      full_r[upd_idx] <= upd_full;
    end
  end

  // priority pick, lowest index wins
  always_comb begin
    first_idx = '0;
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      if (!full_r[k]) begin
        first_idx = WIDX_W'(k);
      end
    end
  end

  assign any_open = ~&full_r;

endmodule
`default_nettype wire

// ===== design/lowest_free_id_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_core: bitmap allocator handing out the lowest id
// Allocates the lowest free id of the open region, releases ids, and grows
// the open region in fixed steps up to the max_id limit and the capacity.
// ----------------------------------------------------------------------------
// Flow: a word taken on start is read from the bitmap, modified and written
//   back in S_MOD, and its result is registered onto the out_valid strobe.
// Busy is high for the read-modify-write cycle and drops with the result
//   strobe, so words never overlap. The receiver cannot stall.
// Reset (rst_n low, synchronous): every id free, 32 bytes open, max_id 256;
//   no clearing pass, the block can take a word as soon as reset is released.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core #(
  parameter int MAX_IDS         = 4096,
  parameter int GROW_STEP_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire lfa_pkg::in_word_t               in_data,
  output logic                                 out_valid,
  output lfa_pkg::out_word_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [lfa_pkg::MAX_ID_W-1:0]    cfg_wdata
);

  // Geometry: the bitmap is kept as 64-bit words of eight bytes each.
  localparam int CAP_BYTES  = MAX_IDS / 8;
  localparam int NUM_WORDS  = MAX_IDS / lfa_pkg::WORD_W;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int BIDX_W     = WIDX_W + 3;
  localparam int BO_W       = $clog2(CAP_BYTES + 1);
  localparam int INIT_OPEN  = (lfa_pkg::INIT_BYTES < CAP_BYTES) ?
                              lfa_pkg::INIT_BYTES : CAP_BYTES;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         op_r;
  logic [lfa_pkg::ID_W-1:0]     rid_r;
  logic [WIDX_W-1:0]            widx_r, widx_nxt;
  logic                         none_r;
  logic [BO_W-1:0]              bytes_open_r, bytes_open_nxt;
  logic [lfa_pkg::MAX_ID_W-1:0] max_id_r;
  logic                         out_valid_r, out_valid_nxt;
  lfa_pkg::out_word_t           out_data_r, out_data_nxt;

  logic                         accept;
  logic [WIDX_W-1:0]            first_idx;
  logic                         any_open;
  logic [lfa_pkg::WORD_W-1:0]   rdata;

  logic                         wr_en;
  logic [lfa_pkg::WORD_W-1:0]   wr_data;

  // allocate datapath
  logic [2:0]                   byte_sel;
  logic [7:0]                   byte_val;
  logic [2:0]                   bit_sel;
  logic [BIDX_W-1:0]            byte_idx;
  logic                         in_region;
  logic [31:0]                  grow_n;
  logic                         grow_ok;
  logic [31:0]                  id_wide;
  logic                         rel_in_region;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Release reads the word holding the id; allocate reads the first word
  // the summary says still has room.
  always_comb begin
    if (in_data.op == lfa_pkg::OP_RELEASE) begin
      widx_nxt = WIDX_W'(32'(in_data.release_id) >> 6);
    end else begin
      widx_nxt = first_idx;
    end
  end

  lfa_full_summary #(
    .NUM_WORDS (NUM_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_summary (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (wr_en),
    .upd_idx   (widx_r),
    .upd_full  (&wr_data),
    .first_idx (first_idx),
    .any_open  (any_open)
  );

  lfa_bitmap_mem #(
    .NUM_WORDS (NUM_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (wr_en),
    .waddr (widx_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (widx_nxt),
    .rdata (rdata)
  );

  // First non-full byte of the word read back, and its lowest clear bit.
  // All bytes past the open region are still clear, so when this byte lies
  // outside the region it is exactly the first byte a growth step opens.
  always_comb begin
    byte_sel = lfa_pkg::first_open_byte(rdata);
    byte_val = rdata[byte_sel*8 +: 8];
    bit_sel  = lfa_pkg::lowest_clear_bit(byte_val);
    byte_idx = {widx_r, byte_sel};
    in_region = !none_r && (32'(byte_idx) < 32'(bytes_open_r));
    id_wide  = 32'({byte_idx, bit_sel});
  end

  // Growth: add one step, trim to max_id/8+1 bytes, cap at capacity.
  always_comb begin
    grow_n = 32'(bytes_open_r) + 32'(GROW_STEP_BYTES);
    if ((grow_n << 3) > 32'(max_id_r)) begin
      grow_n = 32'(max_id_r >> 3) + 32'd1;
    end
    if (grow_n > 32'(CAP_BYTES)) begin
      grow_n = 32'(CAP_BYTES);
    end
    grow_ok = !none_r
              && ((32'(bytes_open_r) << 3) < 32'(max_id_r))
              && (grow_n > 32'(bytes_open_r));
  end

  assign rel_in_region = 32'(rid_r) < (32'(bytes_open_r) << 3);

  // Read-modify-write of the bitmap word and the result word.
  always_comb begin
    wr_en          = 1'b0;
    wr_data        = rdata;
    bytes_open_nxt = bytes_open_r;
    out_data_nxt   = '0;
    out_valid_nxt  = 1'b0;
    state_nxt      = state_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (op_r == lfa_pkg::OP_RELEASE) begin
          if (rel_in_region) begin
            wr_en   = 1'b1;
            wr_data = rdata & ~(lfa_pkg::WORD_W'(1) << rid_r[5:0]);
            out_data_nxt.status = lfa_pkg::STATUS_OK;
          end else begin
            out_data_nxt.status = lfa_pkg::STATUS_OUT_RANGE;
          end
        end else if (in_region || grow_ok) begin
          wr_en   = 1'b1;
          wr_data = rdata | (lfa_pkg::WORD_W'(1) << {byte_sel, bit_sel});
          out_data_nxt.given_id = id_wide[lfa_pkg::ID_W-1:0];
          out_data_nxt.status   = lfa_pkg::STATUS_OK;
          if (!in_region) begin
            bytes_open_nxt = BO_W'(grow_n);
          end
        end else begin
          out_data_nxt.status = lfa_pkg::STATUS_NO_FREE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, registered outputs and region bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      bytes_open_r <= BO_W'(INIT_OPEN);
      max_id_r     <= lfa_pkg::MAX_ID_RESET;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
      bytes_open_r <= bytes_open_nxt;
      if (cfg_we) begin
        max_id_r <= cfg_wdata;
      end
    end
  end

  // Payload: capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.op;
      rid_r  <= in_data.release_id;
      widx_r <= widx_nxt;
      none_r <= !any_open;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== design/lfa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_checker: port-level checks of the allocator
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module lfa_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire lfa_pkg::out_word_t out_data,
  input wire logic               out_valid
);

  // an accepted word keeps the block busy for its read-modify-write cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // every busy cycle ends in exactly one result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle did not end in a result");

  // no result without a preceding busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work");

  // failed results carry no id
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != lfa_pkg::STATUS_OK)) |-> (out_data.given_id == '0))
    else $error("failed result carries an id");

endmodule

bind lowest_free_id_allocator_core lfa_checker u_lfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
`default_nettype wire

// ===== test/tb_lowest_free_id_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator_core: self-checking bench for the id allocator
// Drives allocate and release words through the start/busy handshake and
// predicts every result from a private copy of the id bitmap. It then
// steps max_id through small, growth-cutting and full-range settings.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_IDS         = 4096;
  localparam int GROW_STEP_BYTES = 32;
  localparam int CAP_BYTES       = MAX_IDS / 8;
  // Cycles with no word moving in either direction before the run is called hung.
  localparam int IDLE_LIMIT      = 1000;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow bitmap, open region and max_id. One expected result is
  // queued per accepted word and checked in order.
  // --------------------------------------------------------------------------
  class alloc_scoreboard;
    logic [7:0]                   id_map [CAP_BYTES];
    int unsigned                  open_bytes;
    logic [lfa_pkg::MAX_ID_W-1:0] max_id;
    lfa_pkg::out_word_t           due_q [$];
    int unsigned                  errors;

    function new();
      foreach (id_map[k]) id_map[k] = 8'h00;
      open_bytes = lfa_pkg::INIT_BYTES;
      max_id     = lfa_pkg::MAX_ID_RESET;
      errors     = 0;
    endfunction

    function void set_max_id(logic [lfa_pkg::MAX_ID_W-1:0] v);
      max_id = v;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Update the shadow state for an accepted word and queue its result.
    function void note_word(lfa_pkg::in_word_t w);
      lfa_pkg::out_word_t want;
      int unsigned        first;
      int unsigned        grown;
      logic [2:0]         bit_pos;
      bit                 found;
      want.given_id = '0;
      want.status   = lfa_pkg::STATUS_OK;
      if (w.op == lfa_pkg::OP_RELEASE) begin
        if (w.release_id >= open_bytes * 8) begin
          want.status = lfa_pkg::STATUS_OUT_RANGE;
        end else begin
          id_map[w.release_id[lfa_pkg::ID_W-1:3]][w.release_id[2:0]] = 1'b0;
        end
      end else begin
        first = open_bytes;
        found = 1'b0;
        for (int k = 0; k < open_bytes; k++) begin
          if (!found && id_map[k] != lfa_pkg::BYTE_FULL) begin
            first = k;
            found = 1'b1;
          end
        end
        // Every open byte full: grow by one step, cut at max_id/8+1 and capacity.
        if (!found && open_bytes * 8 < max_id) begin
          grown = open_bytes + GROW_STEP_BYTES;
          if (grown * 8 > max_id) grown = max_id / 8 + 1;
          if (grown > CAP_BYTES) grown = CAP_BYTES;
          if (grown > open_bytes) begin
            for (int k = open_bytes; k < grown; k++) id_map[k] = 8'h00;
            first      = open_bytes;
            open_bytes = grown;
          end
        end
        if (first >= open_bytes) begin
          want.status = lfa_pkg::STATUS_NO_FREE;
        end else begin
          bit_pos = 3'd0;
          found   = 1'b0;
          for (int k = 0; k < 8; k++) begin
            if (!found && !id_map[first][k]) begin
              bit_pos = 3'(k);
              found   = 1'b1;
            end
          end
          id_map[first][bit_pos] = 1'b1;
          want.given_id = lfa_pkg::ID_W'(first * 8 + bit_pos);
        end
      end
      due_q.push_back(want);
    endfunction

    function void check_result(lfa_pkg::out_word_t got);
      lfa_pkg::out_word_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: expected none, got id %0d status %0d",
                 $time, got.given_id, got.status);
        return;
      end
      want = due_q.pop_front();
      if (got.given_id !== want.given_id) begin
        errors++;
        $display("%0t: given_id mismatch: expected %0d, got %0d",
                 $time, want.given_id, got.given_id);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         start     = 1'b0;
  lfa_pkg::in_word_t            in_data   = '0;
  logic                         cfg_we    = 1'b0;
  logic [lfa_pkg::MAX_ID_W-1:0] cfg_wdata = lfa_pkg::MAX_ID_RESET;
  logic                         busy;
  logic                         out_valid;
  lfa_pkg::out_word_t           out_data;

  int unsigned                  quiet_cycles = 0;
  alloc_scoreboard              sb = new();

  always #10 clk = ~clk;

  lowest_free_id_allocator_core #(
    .MAX_IDS         (MAX_IDS),
    .GROW_STEP_BYTES (GROW_STEP_BYTES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Results cannot be held off: check each strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      sb.check_result(out_data);
    end
  end

  // Watchdog: count edges at which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Hold start and the word until an edge sees busy low, then record the word.
  // Start is left high so a following word goes out back to back.
  task automatic send_word(lfa_pkg::in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drain every outstanding result, then write max_id in one cycle.
  task automatic write_max_id(logic [lfa_pkg::MAX_ID_W-1:0] v);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_max_id(v);
  endtask

  function automatic lfa_pkg::in_word_t make_word(logic op, logic [lfa_pkg::ID_W-1:0] id);
    lfa_pkg::in_word_t w;
    w.op         = op;
    w.release_id = id;
    return w;
  endfunction

  // Mostly ids inside the open region, some straddling its edge, some anywhere.
  function automatic logic [lfa_pkg::ID_W-1:0] pick_release_id();
    int unsigned span;
    int unsigned roll;
    span = sb.open_bytes * 8;
    roll = $urandom_range(0, 99);
    if (roll < 75) return lfa_pkg::ID_W'($urandom_range(0, span - 1));
    if (roll < 88) return lfa_pkg::ID_W'(span - 4 + $urandom_range(0, 7));
    return lfa_pkg::ID_W'($urandom_range(0, (1 << lfa_pkg::ID_W) - 1));
  endfunction

  // Random words; idle bursts come and go in stretches when gaps is set.
  task automatic run_phase(int unsigned count, int unsigned alloc_pct, bit gaps);
    lfa_pkg::in_word_t w;
    bit                idle_on;
    idle_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on = gaps && ($urandom_range(0, 2) != 0);
      w.op = ($urandom_range(0, 99) < alloc_pct) ? lfa_pkg::OP_ALLOC : lfa_pkg::OP_RELEASE;
      // The id of an allocate is ignored; fill it anyway so every bit toggles.
      if (w.op == lfa_pkg::OP_RELEASE) begin
        w.release_id = pick_release_id();
      end else begin
        w.release_id = lfa_pkg::ID_W'($urandom_range(0, (1 << lfa_pkg::ID_W) - 1));
      end
      send_word(w);
      if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: releases at and past the region edge, free-id release,
    // lowest-id reuse, and the far ends of release_id.
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd0));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd4095));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd256));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd255));
    send_word(make_word(lfa_pkg::OP_ALLOC,   12'd0));
    send_word(make_word(lfa_pkg::OP_ALLOC,   12'd4095));
    idle_sender(3);
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd0));
    send_word(make_word(lfa_pkg::OP_ALLOC,   12'd0));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'hAAA));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'h555));
    send_word(make_word(lfa_pkg::OP_RELEASE, 12'd1));
    send_word(make_word(lfa_pkg::OP_ALLOC,   12'd0));

    // Smallest max_id: the first 32 bytes stay open, fill them until full.
    write_max_id(13'd1);
    run_phase(400, 85, 1'b1);

    // Just below the initial region: still no growth.
    write_max_id(13'd255);
    run_phase(100, 50, 1'b1);

    // Growth step cut to max_id/8+1 bytes, then full again.
    write_max_id(13'd300);
    run_phase(200, 80, 1'b1);

    // Largest max_id: grow in full steps.
    write_max_id(13'd4096);
    run_phase(900, 85, 1'b1);

    // Random setting, sender runs flat out to the end.
    write_max_id(lfa_pkg::MAX_ID_W'($urandom_range(1, 4096)));
    run_phase(150, 70, 1'b0);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lfa_pkg.sv
design/lfa_bitmap_mem.sv
design/lfa_full_summary.sv
design/lowest_free_id_allocator_core.sv
design/lfa_checker.sv
test/tb_lowest_free_id_allocator_core.sv
